@@ hw/rtl/mspan_pkg.sv @@
// Shared types, field widths, codes and controller/datapath interface structs for the span block.
package mspan_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_TERMS_DEF     = 8;
    localparam int MAX_POSITIONS_DEF = 64;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field widths of the request, result and register
    localparam int MODE_W       = 2;
    localparam int TERM_FIELD_W = 3;
    localparam int POS_FIELD_W  = 16;
    localparam int LIMIT_W      = 16;
    localparam int SPAN_W       = 17;
    localparam int STATUS_W     = 3;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0]  TERM_COUNT_RESET = 4'd1;
    localparam logic [SPAN_W-1:0] SPAN_MAX         = 17'h1FFFF;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BODY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TITLE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_WINDOW = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NARROW    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [TERM_FIELD_W-1:0] term;
        logic [POS_FIELD_W-1:0]  position;
        logic [LIMIT_W-1:0]      window_limit;
    } request_t;

    typedef struct packed {
        logic [SPAN_W-1:0]   span;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LD_RD,
        ST_LD_EV,
        ST_LD_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_CP_START,
        ST_CP_RD,
        ST_CP_EV,
        ST_CP_WIN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                accept;
        logic                idx_clr;
        logic                idx_inc;
        logic                idx_from_len;
        logic                ins_from_idx;
        logic                set_ovf;
        logic                ld_rd;
        logic                sh_rd;
        logic                sh_wr;
        logic                ins_wr;
        logic                cp_init;
        logic                status_wr;
        logic [STATUS_W-1:0] status_code;
        logic                cp_rd;
        logic                cp_ev;
        logic                win_record;
        logic                cur_adv;
        logic                finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mode_load;
        logic mode_compute;
        logic term_ok;
        logic idx_eq_len;
        logic ev_eq;
        logic ev_gt;
        logic list_full;
        logic idx_eq_ins;
        logic ovf;
        logic any_empty;
        logic idx_last;
        logic title_stop;
        logic narrow;
        logic cur_last;
    } stat_t;

endpackage

@@ hw/rtl/mspan_ctrl.sv @@
// Controller state machine: sequences sorted insertion and the window sweep.
module mspan_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mspan_pkg::stat_t stat,
    output mspan_pkg::cmd_t  cmd,
    output logic            busy
);
    import mspan_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.mode_load)
                begin
                    if (stat.term_ok)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_LD_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (stat.mode_compute)
                begin
                    state_next = ST_CP_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LD_RD:
            begin
                if (stat.idx_eq_len)
                begin
                    cmd.ins_from_idx = 1'b1;
                    state_next       = ST_LD_CHK;
                end
                else
                begin
                    cmd.ld_rd  = 1'b1;
                    state_next = ST_LD_EV;
                end
            end
            ST_LD_EV:
            begin
                priority if (stat.ev_eq)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.ev_gt)
                begin
                    cmd.ins_from_idx = 1'b1;
                    state_next       = ST_LD_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_LD_RD;
                end
            end
            ST_LD_CHK:
            begin
                if (stat.list_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.idx_from_len = 1'b1;
                    state_next       = ST_SH_RD;
                end
            end
            ST_SH_RD:
            begin
                if (stat.idx_eq_ins)
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_SH_RD;
            end
            ST_CP_START:
            begin
                cmd.cp_init = 1'b1;
                priority if (stat.ovf)
                begin
                    cmd.status_wr   = 1'b1;
                    cmd.status_code = STATUS_OVERFLOW;
                    cmd.finish      = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (stat.any_empty)
                begin
                    cmd.status_wr   = 1'b1;
                    cmd.status_code = STATUS_EMPTY;
                    cmd.finish      = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CP_RD;
                end
            end
            ST_CP_RD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = ST_CP_EV;
            end
            ST_CP_EV:
            begin
                cmd.cp_ev  = 1'b1;
                state_next = stat.idx_last ? ST_CP_WIN : ST_CP_RD;
            end
            ST_CP_WIN:
            begin
                priority if (stat.title_stop)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.narrow || stat.cur_last)
                begin
                    cmd.win_record = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.win_record = 1'b1;
                    cmd.cur_adv    = 1'b1;
                    cmd.idx_clr    = 1'b1;
                    state_next     = ST_CP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mspan_dp.sv @@
// Datapath: position store, list lengths, cursors, window registers and result register.
module mspan_dp #(
    parameter int MAX_TERMS     = mspan_pkg::MAX_TERMS_DEF,
    parameter int MAX_POSITIONS = mspan_pkg::MAX_POSITIONS_DEF,
    parameter int POSITION_BITS = mspan_pkg::POSITION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mspan_pkg::request_t          req,
    input  logic                         cfg_wr_en,
    input  logic [mspan_pkg::CFG_W-1:0]  cfg_wr_data,
    input  mspan_pkg::cmd_t              cmd,
    output mspan_pkg::stat_t             stat,
    output logic                         done,
    output mspan_pkg::result_t           res
);
    import mspan_pkg::*;

    localparam int DEPTH   = MAX_TERMS * MAX_POSITIONS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TERM_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int LEN_W   = $clog2(MAX_POSITIONS + 1);
    localparam int CUR_W   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int IDX_TOP = (MAX_POSITIONS > MAX_TERMS) ? MAX_POSITIONS : MAX_TERMS;
    localparam int IDX_W   = $clog2(IDX_TOP + 1);
    localparam int N_W     = $clog2(MAX_TERMS + 1);
    localparam int WID_W   = POSITION_BITS + 1;
    localparam int CMP_W   = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;

    // Position store and its registered read port
    logic [POSITION_BITS-1:0] mem [DEPTH];
    logic [POSITION_BITS-1:0] rd_data_reg;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [POSITION_BITS-1:0] wr_data;

    // List state
    logic [LEN_W-1:0] len_reg  [MAX_TERMS];
    logic [LEN_W-1:0] len_next [MAX_TERMS];
    logic [CUR_W-1:0] cur_reg  [MAX_TERMS];
    logic [CUR_W-1:0] cur_next [MAX_TERMS];
    logic             ovf_reg;
    logic             ovf_next;
    logic [CFG_W-1:0] tc_reg;

    // Latched request
    logic [MODE_W-1:0]        mode_reg;
    logic [TERM_FIELD_W-1:0]  term_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    // Scan and sweep registers
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic [LEN_W-1:0]         ins_reg;
    logic [LEN_W-1:0]         ins_next;
    logic [POSITION_BITS-1:0] lo_reg;
    logic [POSITION_BITS-1:0] lo_next;
    logic [POSITION_BITS-1:0] hi_reg;
    logic [POSITION_BITS-1:0] hi_next;
    logic [TERM_W-1:0]        lo_idx_reg;
    logic [TERM_W-1:0]        lo_idx_next;
    logic [WID_W-1:0]         best_reg;
    logic [WID_W-1:0]         best_next;
    logic                     found_reg;
    logic                     found_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic                     done_reg;
    logic                     done_next;
    result_t                  res_reg;
    result_t                  res_next;

    // Derived values
    logic [TERM_W-1:0]  term_idx;
    logic [TERM_W-1:0]  cur_term;
    logic [N_W-1:0]     n_eff;
    logic [WID_W-1:0]   width;
    logic               any_empty;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [TERM_W-1:0] t,
                                                  input logic [31:0] off);
        return ADDR_W'(32'(t) * 32'(MAX_POSITIONS) + off);
    endfunction

    assign term_idx = TERM_W'(term_reg);
    assign cur_term = idx_reg[TERM_W-1:0];
    assign width    = WID_W'(hi_reg) - WID_W'(lo_reg) + WID_W'(1);

    // Clamp the term count into 1..MAX_TERMS
    always_comb
    begin
        if (tc_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (32'(tc_reg) > 32'(MAX_TERMS))
        begin
            n_eff = N_W'(MAX_TERMS);
        end
        else
        begin
            n_eff = N_W'(tc_reg);
        end
    end

    // Flag any taking-part list that is empty
    always_comb
    begin
        any_empty = 1'b0;
        for (int t = 0; t < MAX_TERMS; t++)
        begin
            if ((32'(t) < 32'(n_eff)) && (len_reg[t] == '0))
            begin
                any_empty = 1'b1;
            end
        end
    end

    // Report status to the controller
    always_comb
    begin
        stat.mode_load    = (mode_reg == MODE_LOAD);
        stat.mode_compute = (mode_reg == MODE_BODY) || (mode_reg == MODE_TITLE);
        stat.term_ok      = (32'(term_reg) < 32'(MAX_TERMS));
        stat.idx_eq_len   = (32'(idx_reg) == 32'(len_reg[term_idx]));
        stat.ev_eq        = (rd_data_reg == pos_reg);
        stat.ev_gt        = (rd_data_reg > pos_reg);
        stat.list_full    = (32'(len_reg[term_idx]) >= 32'(MAX_POSITIONS));
        stat.idx_eq_ins   = (32'(idx_reg) == 32'(ins_reg));
        stat.ovf          = ovf_reg;
        stat.any_empty    = any_empty;
        stat.idx_last     = (32'(idx_reg) + 32'd1 == 32'(n_eff));
        stat.title_stop   = (mode_reg == MODE_TITLE) && (CMP_W'(hi_reg) >= CMP_W'(limit_reg));
        stat.narrow       = (width < WID_W'(n_eff));
        stat.cur_last     = (32'(cur_reg[lo_idx_reg]) + 32'd1 >= 32'(len_reg[lo_idx_reg]));
    end

    // Steer the store ports
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (cmd.ld_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = addr_of(term_idx, 32'(idx_reg));
        end
        if (cmd.sh_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = addr_of(term_idx, 32'(idx_reg) - 32'd1);
        end
        if (cmd.cp_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = addr_of(cur_term, 32'(cur_reg[cur_term]));
        end
        if (cmd.sh_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_of(term_idx, 32'(idx_reg));
            wr_data = rd_data_reg;
        end
        if (cmd.ins_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_of(term_idx, 32'(ins_reg));
            wr_data = pos_reg;
        end
    end

    // Write and read the position store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Compute the next datapath state
    always_comb
    begin
        len_next    = len_reg;
        cur_next    = cur_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        ins_next    = ins_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        lo_idx_next = lo_idx_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        res_next    = res_reg;

        // Advance the scan index
        priority if (cmd.idx_clr || cmd.cp_init)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc || cmd.cp_ev)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else if (cmd.idx_from_len)
        begin
            idx_next = IDX_W'(len_reg[term_idx]);
        end
        else if (cmd.sh_wr)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end

        if (cmd.ins_from_idx)
        begin
            ins_next = LEN_W'(idx_reg);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.ins_wr)
        begin
            len_next[term_idx] = len_reg[term_idx] + LEN_W'(1);
        end

        // Start a compute request
        if (cmd.cp_init)
        begin
            found_next  = 1'b0;
            status_next = STATUS_OK;
        end
        if (cmd.status_wr)
        begin
            status_next = cmd.status_code;
        end

        // Track the smallest and largest cursor position
        if (cmd.cp_ev)
        begin
            if (idx_reg == '0)
            begin
                lo_next     = rd_data_reg;
                hi_next     = rd_data_reg;
                lo_idx_next = '0;
            end
            else
            begin
                if (rd_data_reg < lo_reg)
                begin
                    lo_next     = rd_data_reg;
                    lo_idx_next = cur_term;
                end
                if (rd_data_reg > hi_reg)
                begin
                    hi_next = rd_data_reg;
                end
            end
        end

        // Record the current window
        if (cmd.win_record)
        begin
            if (width < WID_W'(n_eff))
            begin
                status_next = STATUS_NARROW;
                best_next   = width;
                found_next  = 1'b1;
            end
            else if (!found_reg || (width < best_reg))
            begin
                best_next  = width;
                found_next = 1'b1;
            end
        end

        if (cmd.cur_adv)
        begin
            cur_next[lo_idx_reg] = cur_reg[lo_idx_reg] + CUR_W'(1);
        end

        // Emit the result and drop all lists
        if (cmd.finish)
        begin
            done_next = 1'b1;
            if ((status_next == STATUS_OK) && !found_next)
            begin
                res_next.status = STATUS_NO_WINDOW;
            end
            else
            begin
                res_next.status = status_next;
            end
            if (!found_next)
            begin
                res_next.span = '0;
            end
            else if (32'(best_next) > 32'(SPAN_MAX))
            begin
                res_next.span = SPAN_MAX;
            end
            else
            begin
                res_next.span = SPAN_W'(best_next);
            end
            for (int t = 0; t < MAX_TERMS; t++)
            begin
                len_next[t] = '0;
                cur_next[t] = '0;
            end
            ovf_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < MAX_TERMS; t++)
            begin
                len_reg[t] <= '0;
                cur_reg[t] <= '0;
            end
            ovf_reg    <= 1'b0;
            tc_reg     <= TERM_COUNT_RESET;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= STATUS_OK;
            done_reg   <= 1'b0;
            mode_reg   <= MODE_LOAD;
        end
        else
        begin
            len_reg    <= len_next;
            cur_reg    <= cur_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            if (cfg_wr_en)
            begin
                tc_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                mode_reg <= req.mode;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            term_reg  <= req.term;
            pos_reg   <= POSITION_BITS'(req.position);
            limit_reg <= req.window_limit;
        end
        ins_reg    <= ins_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lo_idx_reg <= lo_idx_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ hw/rtl/min_span_over_term_positions.sv @@
// Top level of the minimum term-position span block: controller plus datapath.
//
//   Channel   Signals                   Direction  Handshake
//   request   start, busy, req          in         taken when start && !busy
//   result    done, res                 out        valid for the one cycle done is high
//   config    cfg_wr_en, cfg_wr_data    in         written when cfg_wr_en is high
//
// Every step is bounded by the position store, used for one read or write per cycle
// with registered read data. How long busy stays high after a load request is taken depends
// on where the new entry lands, ahead of an existing one or at the tail, and it is shorter
// for a duplicate or a dropped load. For a compute request it grows with the sweep steps and
// the number of terms, and is shortest when the request ends on overflow or an empty list;
// done rises in the same cycle as busy falls.
// Reset empties all lists at once and sets the term count to 1; no clearing pass runs.
// The receiver cannot hold results off: done is high for exactly one cycle per result.
module min_span_over_term_positions #(
    parameter int MAX_TERMS     = mspan_pkg::MAX_TERMS_DEF,
    parameter int MAX_POSITIONS = mspan_pkg::MAX_POSITIONS_DEF,
    parameter int POSITION_BITS = mspan_pkg::POSITION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mspan_pkg::request_t         req,
    output logic                        done,
    output mspan_pkg::result_t          res,
    input  logic                        cfg_wr_en,
    input  logic [mspan_pkg::CFG_W-1:0] cfg_wr_data
);
    import mspan_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence requests
    mspan_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Store lists and run the sweep
    mspan_dp #(
        .MAX_TERMS     (MAX_TERMS),
        .MAX_POSITIONS (MAX_POSITIONS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .res         (res)
    );

endmodule

@@ test/min_span_over_term_positions_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the minimum term-position span block, with a span scoreboard.
module min_span_over_term_positions_tb;
    import mspan_pkg::*;

    localparam int unsigned TERMS         = MAX_TERMS_DEF;
    localparam int unsigned LIST_DEPTH    = MAX_POSITIONS_DEF;
    localparam int unsigned RANDOM_ITEMS  = 650;
    localparam int unsigned MIN_SPANS     = 40;
    localparam int unsigned SETTLE_CYCLES = 160;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Track lists, register and expected spans; check each result against the oldest one
    class span_scoreboard;
        logic [POS_FIELD_W-1:0] positions [TERMS][LIST_DEPTH];
        int unsigned list_len [TERMS];
        bit overflowed;
        logic [CFG_W-1:0] term_count;
        result_t pending_spans [$];
        int unsigned taken;
        int unsigned spans_due;
        int unsigned failures;
        int unsigned status_hits [5];

        function new();
            term_count = TERM_COUNT_RESET;
            clear_lists();
        endfunction

        function void clear_lists();
            foreach (list_len[i]) list_len[i] = 0;
            overflowed = 1'b0;
        endfunction

        function int unsigned active_terms();
            if (term_count == 0)
                return 1;
            if (32'(term_count) > TERMS)
                return TERMS;
            return 32'(term_count);
        endfunction

        // Insert in ascending order, drop duplicates, flag a load into a full list
        function void insert_position(int unsigned t, logic [POS_FIELD_W-1:0] pos);
            int unsigned i, j, len;
            len = list_len[t];
            for (i = 0; i < len; i++)
            begin
                if (positions[t][i] == pos)
                    return;
                if (positions[t][i] > pos)
                    break;
            end
            if (len >= LIST_DEPTH)
            begin
                overflowed = 1'b1;
                return;
            end
            for (j = len; j > i; j--)
                positions[t][j] = positions[t][j-1];
            positions[t][i] = pos;
            list_len[t] = len + 1;
        endfunction

        // Slide the k-way window: advance the term holding the smallest position
        function result_t sweep_span(bit title, logic [LIMIT_W-1:0] limit);
            int unsigned n, t, lo, hi, lo_idx, width, best;
            int unsigned cur [TERMS];
            bit found;
            result_t outcome;
            n = active_terms();
            best = 0;
            found = 1'b0;
            outcome.status = STATUS_OK;
            if (overflowed)
                outcome.status = STATUS_OVERFLOW;
            else
            begin
                for (t = 0; t < n; t++)
                    if (list_len[t] == 0)
                        outcome.status = STATUS_EMPTY;
            end
            if (outcome.status == STATUS_OK)
            begin
                foreach (cur[i]) cur[i] = 0;
                while (1'b1)
                begin
                    lo = 32'(positions[0][cur[0]]);
                    hi = lo;
                    lo_idx = 0;
                    for (t = 1; t < n; t++)
                    begin
                        if (32'(positions[t][cur[t]]) < lo)
                        begin
                            lo = 32'(positions[t][cur[t]]);
                            lo_idx = t;
                        end
                        if (32'(positions[t][cur[t]]) > hi)
                            hi = 32'(positions[t][cur[t]]);
                    end
                    if (title && hi >= 32'(limit))
                        break;
                    width = hi - lo + 1;
                    if (width < n)
                    begin
                        outcome.status = STATUS_NARROW;
                        best = width;
                        found = 1'b1;
                        break;
                    end
                    if (!found || width < best)
                    begin
                        best = width;
                        found = 1'b1;
                    end
                    if (cur[lo_idx] + 1 >= list_len[lo_idx])
                        break;
                    cur[lo_idx]++;
                end
                if (!found)
                    outcome.status = STATUS_NO_WINDOW;
            end
            if (!found)
                best = 0;
            if (best > 32'(SPAN_MAX))
                best = 32'(SPAN_MAX);
            outcome.span = best[SPAN_W-1:0];
            clear_lists();
            return outcome;
        endfunction

        // Apply an accepted request to the lists; queue a span for compute requests
        function void note_request(request_t r);
            result_t due;
            if (r.mode == MODE_LOAD)
            begin
                taken++;
                insert_position(32'(r.term), r.position);
            end
            else if (r.mode == MODE_BODY || r.mode == MODE_TITLE)
            begin
                taken++;
                due = sweep_span(r.mode == MODE_TITLE, r.window_limit);
                pending_spans.insert(pending_spans.size(), due);
                spans_due++;
                status_hits[due.status]++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_spans.size() == 0)
            begin
                $error("unexpected result: span %0d status %0d", got.span, got.status);
                failures++;
                return;
            end
            want = pending_spans.pop_front();
            if (got.span !== want.span)
            begin
                $error("span mismatch: expected %0d, got %0d", want.span, got.span);
                failures++;
            end
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    request_t       req = '0;
    logic           done;
    result_t        res;
    logic           cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    span_scoreboard sb;
    bit             quiet = 1'b0;
    int unsigned    cfg_writes = 0;

    min_span_over_term_positions u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(res);
    end

    // Drive one request, idling at random beforehand, and hold it until taken
    task automatic issue(logic [MODE_W-1:0] mode, int unsigned term, int unsigned pos,
                         int unsigned limit);
        request_t r;
        int unsigned gap;
        r.mode = mode;
        r.term = term[TERM_FIELD_W-1:0];
        r.position = pos[POS_FIELD_W-1:0];
        r.window_limit = limit[LIMIT_W-1:0];
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 16)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    // Drop start and wait until every span is back and the block has gone quiet
    task automatic settle();
        start <= 1'b0;
        while (sb.pending_spans.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_term_count(int unsigned value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[CFG_W-1:0];
        @(posedge clk);
        sb.term_count = value[CFG_W-1:0];
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // Load shuffled clustered positions for the active terms or one more, then compute
    task automatic run_window_case();
        int unsigned n, n_load, spread, base, k, t, i, j, skip_term, swap;
        int unsigned term_q [$];
        int unsigned pos_q [$];
        bit hole;
        n = sb.active_terms();
        case ($urandom_range(0, 3))
            0: spread = 3;
            1: spread = 24;
            2: spread = 600;
            default: spread = 65535;
        endcase
        base = $urandom_range(0, 65535 - spread);
        hole = ($urandom_range(0, 99) < 8);
        skip_term = $urandom_range(0, n - 1);
        n_load = (n < TERMS && $urandom_range(0, 3) == 0) ? n + 1 : n;
        for (t = 0; t < n_load; t++)
        begin
            if (hole && t == skip_term)
                continue;
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
            for (i = 0; i < k; i++)
            begin
                term_q.insert(term_q.size(), t);
                pos_q.insert(pos_q.size(), base + $urandom_range(0, spread));
            end
        end
        for (i = term_q.size(); i > 1; i--)
        begin
            j = $urandom_range(0, i - 1);
            swap = term_q[i-1];
            term_q[i-1] = term_q[j];
            term_q[j] = swap;
            swap = pos_q[i-1];
            pos_q[i-1] = pos_q[j];
            pos_q[j] = swap;
        end
        foreach (term_q[m]) issue(MODE_LOAD, term_q[m], pos_q[m], $urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: k = 0;
            1: k = 65535;
            2: k = base + $urandom_range(0, spread);
            default: k = $urandom_range(0, 65535);
        endcase
        issue($urandom_range(0, 1) ? MODE_TITLE : MODE_BODY, $urandom_range(0, 7),
              $urandom_range(0, 65535), k);
        // Compute again on freshly cleared lists now and then
        if ($urandom_range(0, 19) == 0)
            issue(MODE_BODY, 0, 0, $urandom_range(0, 65535));
    endtask

    // Push one list to its depth and sometimes past it
    task automatic run_fill_case();
        int unsigned victim, count, i, t;
        victim = $urandom_range(0, TERMS - 1);
        count = LIST_DEPTH + $urandom_range(0, 3);
        for (i = 0; i < count; i++)
            issue(MODE_LOAD, victim, $urandom_range(0, 65535), 0);
        for (t = 0; t < sb.active_terms(); t++)
            if (t != victim)
                issue(MODE_LOAD, t, $urandom_range(0, 65535), 0);
        issue(MODE_BODY, 0, 0, $urandom_range(0, 65535));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 4))
            issue(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 7),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    initial
    begin
        int unsigned t, seq, goal, quiet_from, pick;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, duplicates, unused mode, title with no window
        issue(MODE_BODY, 0, 0, 0);
        issue(MODE_LOAD, 0, 65535, 0);
        issue(MODE_LOAD, 0, 0, 65535);
        issue(MODE_LOAD, 0, 0, 0);
        issue(MODE_UNUSED, 7, 65535, 65535);
        issue(MODE_BODY, 2, 0, 0);
        issue(MODE_LOAD, 7, 1234, 0);
        issue(MODE_LOAD, 0, 40, 0);
        issue(MODE_TITLE, 0, 0, 0);

        // Directed: term count zero acts as one
        write_term_count(0);
        issue(MODE_LOAD, 0, 7, 0);
        issue(MODE_TITLE, 0, 0, 65535);

        // Directed: all eight terms packed tighter than the term count
        write_term_count(TERMS);
        for (t = 0; t < TERMS; t++)
            issue(MODE_LOAD, t, 200 + t % 4, 0);
        issue(MODE_BODY, 0, 0, 0);

        // Directed: out-of-range count, widest possible window
        write_term_count(15);
        issue(MODE_LOAD, 0, 0, 0);
        for (t = 1; t < TERMS; t++)
            issue(MODE_LOAD, t, 65535, 0);
        issue(MODE_BODY, 0, 0, 0);

        // Random: mostly well-formed load-then-compute cases with a quiet stretch
        goal = sb.taken + RANDOM_ITEMS;
        quiet_from = sb.taken + 250;
        seq = 0;
        while (sb.taken < goal || sb.spans_due < MIN_SPANS)
        begin
            if (seq % 6 == 5)
                write_term_count($urandom_range(0, 15));
            quiet = (sb.taken >= quiet_from && sb.taken < quiet_from + 170);
            pick = $urandom_range(0, 99);
            if (seq == 0 || pick < 3)
                run_fill_case();
            else if (pick < 15)
                run_noise();
            else
                run_window_case();
            seq++;
        end
        quiet = 1'b0;

        settle();
        $display("Ran %0d requests with %0d span results over %0d term-count writes.",
                 sb.taken, sb.spans_due, cfg_writes);
        $display("Status mix: ok %0d, no window %0d, empty %0d, narrow %0d, overflow %0d",
                 sb.status_hits[STATUS_OK], sb.status_hits[STATUS_NO_WINDOW],
                 sb.status_hits[STATUS_EMPTY], sb.status_hits[STATUS_NARROW],
                 sb.status_hits[STATUS_OVERFLOW]);
        if (sb.failures == 0)
            $display("min_span_over_term_positions verification clean");
        else
            $display("min_span_over_term_positions verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #40_000_000;
        $display("min_span_over_term_positions verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mspan_pkg.sv
hw/rtl/mspan_ctrl.sv
hw/rtl/mspan_dp.sv
hw/rtl/min_span_over_term_positions.sv
test/min_span_over_term_positions_tb.sv
